// File: rtl/core/cdtb_pkg.sv
// Shared definitions for the character display text buffer: geometry,
// opcodes, character codes and the controller/datapath interface structs.
// No dependencies.
package cdtb_pkg;

  localparam int MAX_COLUMNS = 32;
  localparam int MAX_ROWS    = 4;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int ADDR_W      = COL_W + ROW_W;
  localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;

  // Command opcodes
  localparam logic [2:0] OP_WRITE     = 3'd0;
  localparam logic [2:0] OP_SET       = 3'd1;
  localparam logic [2:0] OP_CLEAR     = 3'd2;
  localparam logic [2:0] OP_HOME      = 3'd3;
  localparam logic [2:0] OP_SCROLL_L  = 3'd4;
  localparam logic [2:0] OP_SCROLL_R  = 3'd5;
  localparam logic [2:0] OP_READ      = 3'd6;

  // Character codes
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Configuration register indexes (address bit 2)
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  typedef struct packed {
    logic latch_cmd;
    logic exec;
    logic sweep_init;
    logic sweep_step;
    logic load_out;
  } cdtb_cmd_t;

  typedef struct packed {
    logic op_sweep;
    logic sweep_done;
  } cdtb_status_t;

endpackage

// File: rtl/core/cdtb_ctrl.sv
// Sequencer for the text buffer: accepts a command, runs it, hands the
// result to the output register. Depends on cdtb_pkg.
module cdtb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  cdtb_pkg::cdtb_status_t status,
  output cdtb_pkg::cdtb_cmd_t    cmd
);
  import cdtb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid;
  logic   out_free;

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.latch_cmd = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.op_sweep) begin
          cmd.sweep_init = 1'b1;
          state_next     = ST_SWEEP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/cdtb_datapath.sv
// Datapath of the text buffer: command latch, cursor, cell memory with
// valid bits, sweep counters for scroll and clear, and result register.
// Depends on cdtb_pkg.
module cdtb_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  cdtb_pkg::cdtb_cmd_t          cmd,
  output cdtb_pkg::cdtb_status_t       status,
  input  logic [5:0]                  cfg_columns,
  input  logic [2:0]                  cfg_rows,
  input  logic [2:0]                  opcode,
  input  logic [7:0]                  char_code,
  input  logic [7:0]                  column,
  input  logic [7:0]                  line,
  output logic [7:0]                  cell_value,
  output logic [cdtb_pkg::COL_W-1:0]  cursor_column,
  output logic [cdtb_pkg::ROW_W-1:0]  cursor_line
);
  import cdtb_pkg::*;

  // Latched command
  logic [2:0] op;
  logic [7:0] ch;
  logic [7:0] col_in;
  logic [7:0] line_in;

  // Cursor
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;

  // Cell store
  logic [7:0]      text_mem [CELL_COUNT];
  logic            cell_valid [CELL_COUNT];
  logic [7:0]      mem_q;
  logic            vld_q;
  logic [7:0]      rd_data;
  logic            rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic            wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]      wr_data;

  // Sweep
  logic [5:0]       k;
  logic [ROW_W-1:0] srow;
  logic [7:0]       keep;

  // Effective geometry
  logic [5:0] eff_cols;
  logic [2:0] eff_rows;
  logic [5:0] cols_m1;
  logic [2:0] rows_m1;
  logic [COL_W-1:0] clamp_col;
  logic [ROW_W-1:0] clamp_row;

  // Write-char cursor math
  logic [5:0] nc;
  logic [2:0] nr;
  logic       do_store;

  logic       scroll_left;
  logic       row_end;
  logic [5:0] rd_col6;
  logic [5:0] wr_col6;

  always_comb begin
    if (cfg_columns == 6'd0) eff_cols = 6'd1;
    else if (cfg_columns > 6'(MAX_COLUMNS)) eff_cols = 6'(MAX_COLUMNS);
    else eff_cols = cfg_columns;
    if (cfg_rows == 3'd0) eff_rows = 3'd1;
    else if (cfg_rows > 3'(MAX_ROWS)) eff_rows = 3'(MAX_ROWS);
    else eff_rows = cfg_rows;
  end

  assign cols_m1   = eff_cols - 6'd1;
  assign rows_m1   = eff_rows - 3'd1;
  assign clamp_col = (col_in > {2'b00, cols_m1}) ? cols_m1[COL_W-1:0] : col_in[COL_W-1:0];
  assign clamp_row = (line_in > {5'b00000, rows_m1}) ? rows_m1[ROW_W-1:0]
                                                     : line_in[ROW_W-1:0];

  // Cursor advance for a written byte, with the wrap checks
  always_comb begin
    nc       = {1'b0, cur_col};
    nr       = {1'b0, cur_row};
    do_store = 1'b0;
    if (ch == CH_NEWLINE) begin
      nc = 6'd0;
      nr = nr + 3'd1;
    end else if (ch == CH_RETURN) begin
      nc = 6'd0;
    end else if (({1'b0, cur_col} < eff_cols) && ({1'b0, cur_row} < eff_rows)) begin
      do_store = 1'b1;
      nc       = nc + 6'd1;
    end
    if (nc >= eff_cols) begin
      nc = 6'd0;
      nr = nr + 3'd1;
    end
    if (nr >= eff_rows) nr = 3'd0;
  end

  // Sweep addressing: scroll reads column k in sweep order and writes two
  // steps behind; clear writes a space at column k
  assign scroll_left = (op == OP_SCROLL_L);
  assign row_end     = (k == eff_cols + 6'd1);
  assign rd_col6     = scroll_left ? k : (cols_m1 - k);
  always_comb begin
    if (row_end) wr_col6 = scroll_left ? cols_m1 : 6'd0;
    else wr_col6 = scroll_left ? (k - 6'd2) : (eff_cols + 6'd1 - k);
  end

  assign status.op_sweep   = (op == OP_SCROLL_L) || (op == OP_SCROLL_R) || (op == OP_CLEAR);
  assign status.sweep_done = row_end && (srow == rows_m1[ROW_W-1:0]);

  // Memory port muxing
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = {clamp_row, clamp_col};
    wr_en      = 1'b0;
    wr_addr    = {cur_row, cur_col};
    wr_data    = ch;
    if (cmd.exec) begin
      case (op)
        OP_WRITE: wr_en = do_store;
        OP_READ:  rd_en = 1'b1;
        default:  ;
      endcase
    end else if (cmd.sweep_step) begin
      rd_addr = {srow, rd_col6[COL_W-1:0]};
      wr_addr = {srow, wr_col6[COL_W-1:0]};
      if (op == OP_CLEAR) begin
        wr_en   = (k < eff_cols);
        wr_addr = {srow, k[COL_W-1:0]};
        wr_data = CH_SPACE;
      end else begin
        rd_en = (k < eff_cols);
        if (row_end) begin
          wr_en   = 1'b1;
          wr_data = keep;
        end else begin
          wr_en   = (k >= 6'd2);
          wr_data = rd_data;
        end
      end
    end
  end

  assign rd_data = vld_q ? mem_q : CH_SPACE;

  always_ff @(posedge clk) begin
    if (wr_en) text_mem[wr_addr] <= wr_data;
    if (rd_en) mem_q <= text_mem[rd_addr];
  end

  // Valid bits: an entry never written since reset reads as a space
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELL_COUNT; i++) cell_valid[i] <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      if (rd_en) vld_q <= cell_valid[rd_addr];
      if (wr_en) cell_valid[wr_addr] <= 1'b1;
    end
  end

  // Command latch and result register
  always_ff @(posedge clk) begin
    if (cmd.latch_cmd) begin
      op      <= opcode;
      ch      <= char_code;
      col_in  <= column;
      line_in <= line;
    end
    if (cmd.load_out) begin
      cell_value    <= (op == OP_READ) ? rd_data : 8'd0;
      cursor_column <= cur_col;
      cursor_line   <= cur_row;
    end
    if (cmd.sweep_step && (k == 6'd1)) keep <= rd_data;
  end

  // Cursor and sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
      k       <= '0;
      srow    <= '0;
    end else begin
      if (cmd.exec) begin
        case (op)
          OP_WRITE: begin
            cur_col <= nc[COL_W-1:0];
            cur_row <= nr[ROW_W-1:0];
          end
          OP_SET: begin
            cur_col <= clamp_col;
            cur_row <= clamp_row;
          end
          OP_CLEAR, OP_HOME: begin
            cur_col <= '0;
            cur_row <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.sweep_init) begin
        k    <= '0;
        srow <= '0;
      end else if (cmd.sweep_step) begin
        if (row_end) begin
          k    <= '0;
          srow <= srow + ROW_W'(1);
        end else begin
          k <= k + 6'd1;
        end
      end
    end
  end

endmodule

// File: rtl/core/character_display_text_buffer.sv
// Top level of the character display text buffer: configuration registers,
// stream packing, controller and datapath. Depends on cdtb_pkg, cdtb_ctrl,
// cdtb_datapath.
//
//   Channel   Dir  Handshake               Content
//   s_axis    in   tvalid/tready           one command beat
//   m_axis    out  tvalid/tready           one result beat per command
//   apb       in   psel/penable/pready     active_columns (0x0), active_rows (0x4)
//
// Sequence: a command is accepted in idle, runs in execute and waits in done
// until the output register is free; the result is loaded as the controller
// returns to idle. Scroll and clear add a sweep state, paced by the single
// write and single read port of the cell memory, which the sweep walks one
// cell per cycle.
// Reset: synchronous, active high; the cursor goes home and every cell
// reads as a space through its valid bit. No clearing pass is needed.
// Stalls: a result waits in the output register while the next command is
// accepted; that command holds in its final state until the register frees.
module character_display_text_buffer (
  input  logic        clk,
  input  logic        rst,
  // s_axis_tdata, from bit 0: opcode[2:0], char_code[10:3], column[18:11],
  // line[26:19], zero fill [31:27]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // m_axis_tdata, from bit 0: cell_value[7:0], cursor_column[12:8],
  // cursor_line[14:13], zero fill [15]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cdtb_pkg::*;

  logic [5:0] active_columns;
  logic [2:0] active_rows;
  logic       reg_write;
  logic       reg_sel;

  cdtb_cmd_t    cmd;
  cdtb_status_t status;

  logic [7:0]       cell_value;
  logic [COL_W-1:0] cursor_column;
  logic [ROW_W-1:0] cursor_line;

  // Registers are word-spaced; decode on the word index only
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_columns <= 6'd16;
      active_rows    <= 3'd2;
    end else if (reg_write) begin
      case (reg_sel)
        REG_COLUMNS: active_columns <= pwdata[5:0];
        REG_ROWS:    active_rows    <= pwdata[2:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_COLUMNS: prdata = {26'd0, active_columns};
      REG_ROWS:    prdata = {29'd0, active_rows};
      default:     prdata = 32'd0;
    endcase
  end

  cdtb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  // Unpack the command beat straight into the datapath latch
  cdtb_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_columns   (active_columns),
    .cfg_rows      (active_rows),
    .opcode        (s_axis_tdata[2:0]),
    .char_code     (s_axis_tdata[10:3]),
    .column        (s_axis_tdata[18:11]),
    .line          (s_axis_tdata[26:19]),
    .cell_value    (cell_value),
    .cursor_column (cursor_column),
    .cursor_line   (cursor_line)
  );

  // Pack the result beat; the top bit is fill
  assign m_axis_tdata = {1'b0, cursor_line, cursor_column, cell_value};

endmodule

// File: tb/sv/character_display_text_buffer_test.sv
// Self-checking testbench for character_display_text_buffer: streams display
// commands, predicts each result beat from a local text store and cursor.
// Depends on cdtb_pkg and the character_display_text_buffer RTL.
module character_display_text_buffer_test;
  import cdtb_pkg::*;

  // Opcode 7 has no name in the package; it leaves everything as it is.
  localparam logic [2:0] OP_IDLE = 3'd7;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 150;   // longer than the slowest scroll
  localparam int MAX_REPORTS     = 10;

  // Command beat, most significant field first so that it packs straight
  // into tdata: opcode sits in the low bits.
  typedef struct packed {
    logic [7:0] line;
    logic [7:0] column;
    logic [7:0] char_code;
    logic [2:0] opcode;
  } display_cmd_t;

  // Result beat, same packing as m_axis_tdata[14:0].
  typedef struct packed {
    logic [1:0] cursor_line;
    logic [4:0] cursor_column;
    logic [7:0] cell_value;
  } display_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  character_display_text_buffer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the display: text store, cursor and the two size registers.
  // The size registers keep the raw bits written; the span helpers clamp.
  // ---------------------------------------------------------------------
  logic [7:0] screen_cells [CELL_COUNT];
  int         cursor_col = 0;
  int         cursor_row = 0;
  logic [5:0] cfg_columns = 6'd16;
  logic [2:0] cfg_rows = 3'd2;

  // Size settings per phase: both extremes of each register and values
  // above the store size, so every register bit toggles.
  int phase_columns [PHASES] = '{32, 1, 0, 63, 7, 33, 20, 2};
  int phase_rows    [PHASES] = '{4, 1, 0, 7, 3, 5, 2, 4};

  display_cmd_t    pending_cmds [$];       // commands waiting for the driver
  display_result_t expected_results [$];   // results owed by the block
  display_cmd_t    cmd_on_bus;
  bit              cmd_busy = 1'b0;        // a beat is on s_axis, not yet taken
  int              burst_left = 1;
  int              gap_left = 0;
  bit              hold_off_req = 1'b0;
  int              hold_left = 0;
  logic [15:0]     stall_pattern = '1;
  int              pattern_age = 0;
  int              fault_count = 0;
  int              idle_cycles = 0;

  function automatic int span_columns();
    if (cfg_columns == 0) return 1;
    if (cfg_columns > MAX_COLUMNS) return MAX_COLUMNS;
    return cfg_columns;
  endfunction

  function automatic int span_rows();
    if (cfg_rows == 0) return 1;
    if (cfg_rows > MAX_ROWS) return MAX_ROWS;
    return cfg_rows;
  endfunction

  // Apply one command to the shadow and return the result it must produce.
  function automatic display_result_t apply_command(display_cmd_t cmd);
    int              ncols;
    int              nrows;
    int              col_sel;
    int              row_sel;
    int              r;
    int              c;
    logic [7:0]      kept;
    display_result_t res;
    ncols = span_columns();
    nrows = span_rows();
    col_sel = (cmd.column > ncols - 1) ? ncols - 1 : cmd.column;
    row_sel = (cmd.line > nrows - 1) ? nrows - 1 : cmd.line;
    res.cell_value = 8'h00;
    case (cmd.opcode)
      OP_WRITE: begin
        if (cmd.char_code == CH_NEWLINE) begin
          cursor_col = 0;
          cursor_row++;
        end else if (cmd.char_code == CH_RETURN) begin
          cursor_col = 0;
        end else if (cursor_col < ncols && cursor_row < nrows) begin
          screen_cells[cursor_row * MAX_COLUMNS + cursor_col] = cmd.char_code;
          cursor_col++;
        end
        // A cursor left outside a shrunk area stores nothing but still wraps.
        if (cursor_col >= ncols) begin
          cursor_col = 0;
          cursor_row++;
        end
        if (cursor_row >= nrows) cursor_row = 0;
      end
      OP_SET: begin
        cursor_col = col_sel;
        cursor_row = row_sel;
      end
      OP_CLEAR: begin
        for (r = 0; r < nrows; r++)
          for (c = 0; c < ncols; c++) screen_cells[r * MAX_COLUMNS + c] = CH_SPACE;
        cursor_col = 0;
        cursor_row = 0;
      end
      OP_HOME: begin
        cursor_col = 0;
        cursor_row = 0;
      end
      OP_SCROLL_L: begin
        for (r = 0; r < nrows; r++) begin
          kept = screen_cells[r * MAX_COLUMNS];
          for (c = 0; c + 1 < ncols; c++)
            screen_cells[r * MAX_COLUMNS + c] = screen_cells[r * MAX_COLUMNS + c + 1];
          screen_cells[r * MAX_COLUMNS + ncols - 1] = kept;
        end
      end
      OP_SCROLL_R: begin
        for (r = 0; r < nrows; r++) begin
          kept = screen_cells[r * MAX_COLUMNS + ncols - 1];
          for (c = ncols - 1; c > 0; c--)
            screen_cells[r * MAX_COLUMNS + c] = screen_cells[r * MAX_COLUMNS + c - 1];
          screen_cells[r * MAX_COLUMNS] = kept;
        end
      end
      OP_READ: res.cell_value = screen_cells[row_sel * MAX_COLUMNS + col_sel];
      default: ;
    endcase
    res.cursor_column = cursor_col[4:0];
    res.cursor_line = cursor_row[1:0];
    return res;
  endfunction

  // Mostly in-range coordinates so reads land on text that was written;
  // the rest spans the whole byte to exercise clamping.
  function automatic logic [7:0] pick_coord(int span);
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, span - 1));
  endfunction

  // Random command weighted toward text entry and reads; clear and scroll
  // are rarer since they sweep the whole store.
  function automatic display_cmd_t random_command();
    display_cmd_t cmd;
    int           pick;
    pick = $urandom_range(0, 99);
    cmd.char_code = 8'($urandom_range(0, 255));
    cmd.column = pick_coord(span_columns());
    cmd.line = pick_coord(span_rows());
    if (pick < 46) begin
      cmd.opcode = OP_WRITE;
      case ($urandom_range(0, 19))
        0, 1: cmd.char_code = CH_NEWLINE;
        2:    cmd.char_code = CH_RETURN;
        default: ;
      endcase
    end else if (pick < 56) cmd.opcode = OP_SET;
    else if (pick < 76) cmd.opcode = OP_READ;
    else if (pick < 83) cmd.opcode = OP_SCROLL_L;
    else if (pick < 90) cmd.opcode = OP_SCROLL_R;
    else if (pick < 94) cmd.opcode = OP_HOME;
    else if (pick < 97) cmd.opcode = OP_CLEAR;
    else cmd.opcode = OP_IDLE;
    return cmd;
  endfunction

  task automatic push_cmd(logic [2:0] op, logic [7:0] ch, logic [7:0] col, logic [7:0] ln);
    display_cmd_t cmd;
    cmd.opcode = op;
    cmd.char_code = ch;
    cmd.column = col;
    cmd.line = ln;
    pending_cmds.push_back(cmd);
  endtask

  // Register write in setup and access phases; the shadow follows once the access completes.
  task automatic write_register(logic reg_index, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_index == REG_COLUMNS) cfg_columns = value[5:0];
    else cfg_rows = value[2:0];
  endtask

  // Hold until the driver is empty and every result beat has come back.
  task automatic drain();
    while (pending_cmds.size() != 0 || cmd_busy || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Command driver: bursts of beats with random gaps. tvalid stays up
  // across back-to-back beats and is only dropped when a gap starts or
  // the queue runs dry.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!cmd_busy) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cmd_on_bus = pending_cmds.pop_front();
        s_axis_tdata <= {5'b0, cmd_on_bus};
        s_axis_tvalid <= 1'b1;
        cmd_busy = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result receiver: tready follows a rotating 16-bit pattern that is
  // redrawn when its age counter runs out (a quarter of the draws are all ones). A
  // hold-off request drops tready for a long count so the block backs up.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off_req || hold_left > 0) begin
      if (hold_off_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        pattern_age = 48;
      end
      pattern_age--;
      m_axis_tready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predict on every accepted command beat, compare every
  // accepted result beat with the oldest prediction, and run the watchdog.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    display_result_t got;
    display_result_t want;
    bit              moved;
    if (!rst) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_command(cmd_on_bus));
        cmd_busy = 1'b0;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got = m_axis_tdata[14:0];
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("unexpected result beat: cell %h col %0d row %0d",
                     got.cell_value, got.cursor_column, got.cursor_line);
        end else begin
          want = expected_results.pop_front();
          if (got.cell_value !== want.cell_value || got.cursor_column !== want.cursor_column
              || got.cursor_line !== want.cursor_line) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
              $display("result mismatch: expected cell %h col %0d row %0d, got cell %h col %0d row %0d",
                       want.cell_value, want.cursor_column, want.cursor_line,
                       got.cell_value, got.cursor_column, got.cursor_line);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("character_display_text_buffer_test: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: directed commands at the reset size, then one random phase
  // per size setting. Each phase ends with the cursor parked at the far
  // corner so the next, possibly smaller, area starts with it outside.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    int k;
    for (k = 0; k < CELL_COUNT; k++) screen_cells[k] = CH_SPACE;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass at the reset size of 16 x 2.
    push_cmd(OP_READ, 8'h00, 8'd0, 8'd0);          // reset content is a space
    push_cmd(OP_WRITE, 8'h00, 8'd0, 8'd0);
    push_cmd(OP_WRITE, 8'hFF, 8'd0, 8'd0);
    push_cmd(OP_WRITE, CH_NEWLINE, 8'd0, 8'd0);
    push_cmd(OP_WRITE, 8'h41, 8'd0, 8'd0);
    push_cmd(OP_WRITE, CH_RETURN, 8'd0, 8'd0);
    push_cmd(OP_WRITE, 8'h42, 8'd0, 8'd0);
    push_cmd(OP_SET, 8'h00, 8'd255, 8'd255);       // clamps to the last cell
    push_cmd(OP_WRITE, 8'h7A, 8'd0, 8'd0);         // past the end: wraps to row 0
    push_cmd(OP_READ, 8'h00, 8'd255, 8'd255);
    push_cmd(OP_SET, 8'h00, 8'd15, 8'd0);
    push_cmd(OP_WRITE, CH_NEWLINE, 8'd0, 8'd0);    // newline to the last row; the next one wraps
    push_cmd(OP_WRITE, CH_NEWLINE, 8'd0, 8'd0);
    push_cmd(OP_SCROLL_L, 8'h00, 8'd0, 8'd0);
    push_cmd(OP_READ, 8'h00, 8'd0, 8'd0);
    push_cmd(OP_READ, 8'h00, 8'd15, 8'd0);
    push_cmd(OP_SCROLL_R, 8'h00, 8'd0, 8'd0);
    push_cmd(OP_READ, 8'h00, 8'd0, 8'd0);
    push_cmd(OP_IDLE, 8'hFF, 8'd255, 8'd255);
    push_cmd(OP_HOME, 8'h00, 8'd0, 8'd0);
    push_cmd(OP_CLEAR, 8'h00, 8'd0, 8'd0);
    push_cmd(OP_READ, 8'h00, 8'd1, 8'd1);
    push_cmd(OP_SET, 8'h00, 8'd255, 8'd255);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      write_register(REG_COLUMNS, 32'(phase_columns[phase]));
      write_register(REG_ROWS, 32'(phase_rows[phase]));
      @(posedge clk);
      for (k = 0; k < ITEMS_PER_PHASE; k++) pending_cmds.push_back(random_command());
      push_cmd(OP_SET, 8'h00, 8'd255, 8'd255);
      // Back up the block once while the driver keeps offering beats.
      if (phase == 0) hold_off_req = 1'b1;
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) fault_count++;
    if (fault_count == 0) begin
      $display("character_display_text_buffer_test: done, clean");
    end else begin
      $display("character_display_text_buffer_test: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cdtb_pkg.sv
rtl/core/cdtb_ctrl.sv
rtl/core/cdtb_datapath.sv
rtl/core/character_display_text_buffer.sv
tb/sv/character_display_text_buffer_test.sv
